// ===== hw/rtl/lbfs_pkg.sv =====
package lbfs_pkg;

  // Geometry of the block store.
  localparam int NUM_BLOCKS  = 64;
  localparam int BLK_W       = $clog2(NUM_BLOCKS);
  localparam int BLOCK_BYTES = 32;
  localparam int OFF_W       = $clog2(BLOCK_BYTES);
  localparam int STORE_DEPTH = NUM_BLOCKS * BLOCK_BYTES;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int NUM_FILES   = 64;
  localparam int FILE_W      = $clog2(NUM_FILES);

  localparam logic [7:0]       NO_BLOCK   = 8'hFF;
  localparam logic [7:0]       DATA_BYTES = 8'(BLOCK_BYTES - 1);
  localparam logic [OFF_W-1:0] LINK_OFF   = OFF_W'(BLOCK_BYTES - 1);

  // Command codes.
  localparam logic [2:0] CMD_OPEN_WR  = 3'd0;
  localparam logic [2:0] CMD_OPEN_APP = 3'd1;
  localparam logic [2:0] CMD_OPEN_RD  = 3'd2;
  localparam logic [2:0] CMD_CLOSE    = 3'd3;
  localparam logic [2:0] CMD_WRITE    = 3'd4;
  localparam logic [2:0] CMD_READ     = 3'd5;
  localparam logic [2:0] CMD_DELETE   = 3'd6;
  localparam logic [2:0] CMD_EXISTS   = 3'd7;

  // Status codes.
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_OPEN   = 3'd1;
  localparam logic [2:0] ST_NOFILE = 3'd2;
  localparam logic [2:0] ST_MODE   = 3'd3;
  localparam logic [2:0] ST_SPACE  = 3'd4;
  localparam logic [2:0] ST_EOF    = 3'd5;

  // Access modes.
  localparam logic [1:0] MODE_CLOSED = 2'd0;
  localparam logic [1:0] MODE_WRITE  = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  typedef struct packed {
    logic [7:0] start_blk;
    logic [1:0] mode;
    logic [7:0] pos;
    logic [7:0] cur_blk;
  } file_entry_t;

  localparam file_entry_t ENTRY_RESET = '{start_blk: NO_BLOCK, mode: MODE_CLOSED,
                                         pos: 8'd0, cur_blk: NO_BLOCK};

  typedef enum logic [3:0] {
    S_IDLE, S_TBL, S_EXEC, S_WREQ, S_WDAT, S_WNEW, S_WBYTE,
    S_RREQ, S_RLNK, S_RBYTE, S_DONE
  } state_t;

  // A link below the flag that names no block is treated as an empty end mark.
  function automatic logic [7:0] filt_link(input logic [7:0] v);
    if (!v[7] && (v >= 8'(NUM_BLOCKS))) return NO_BLOCK;
    return v;
  endfunction

  // Stored length of a last block, saturated to the data bytes of a block.
  function automatic logic [7:0] end_len(input logic [7:0] l, input logic [7:0] when_empty);
    if (l == NO_BLOCK) return when_empty;
    if ({1'b0, l[6:0]} > DATA_BYTES) return DATA_BYTES;
    return {1'b0, l[6:0]};
  endfunction

  // Lowest free block; found flag in the top bit.
  function automatic logic [BLK_W:0] find_free(input logic [NUM_BLOCKS-1:0] map);
    logic [BLK_W:0] r;
    r = '0;
    for (int i = NUM_BLOCKS - 1; i >= 0; i--) begin
      if (map[i]) r = {1'b1, BLK_W'(i)};
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/lbfs_ram.sv =====
module lbfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hw/rtl/linked_block_file_store_core.sv =====
// Channel   Direction  Fields (tdata, lowest bit first)
// s_axis    in         cmd[2:0], file[8:3], data_in[16:9]
// m_axis    out        status[2:0], data_out[10:3]
//
// One command at a time. Open write, append and delete of an existing file
// walk the chain through the block memory port. A write byte may chain a
// new block; a read byte steps to the next block at most once. Synchronous
// reset clears control state and the file table valid bits; the block
// memory is not cleared. A result held on m_axis holds the sequencer in
// its final table write-back, so the next command waits until it is taken.
module linked_block_file_store_core
  import lbfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // cmd, file, data_in, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // status, data_out, zero pad
);

  state_t state, state_next;

  logic [2:0]        cmd_r, cmd_next;
  logic [FILE_W-1:0] file_r, file_next;
  logic [7:0]        din_r, din_next;
  file_entry_t       ent, ent_next;
  logic [BLK_W-1:0]  walk_blk, walk_blk_next;
  logic [BLK_W:0]    walk_n, walk_n_next;
  logic              tries, tries_next;
  logic [2:0]        status_r, status_next;
  logic [7:0]        dout_r, dout_next;

  logic [NUM_BLOCKS-1:0] free_map;
  logic [NUM_FILES-1:0]  tbl_vld;

  logic               b_we;
  logic [ADDR_W-1:0]  b_addr;
  logic [7:0]         b_wdata, b_rdata;
  logic               t_we;
  logic [FILE_W-1:0]  t_addr;
  file_entry_t        t_rdata;

  logic               free_clr, free_set;
  logic [BLK_W-1:0]   free_clr_idx, free_set_idx;
  logic [BLK_W:0]     alloc;
  logic [7:0]         lnk, rlen;
  logic               accept, out_free;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign alloc    = find_free(free_map);
  assign lnk      = filt_link(b_rdata);
  assign rlen     = lnk[7] ? end_len(lnk, DATA_BYTES) : DATA_BYTES;

  assign s_axis_tready = (state == S_IDLE);
  assign t_addr        = (state == S_IDLE) ? s_axis_tdata[8:3] : file_r;
  assign t_we          = (state == S_DONE);

  lbfs_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
    .clk(clk), .we(b_we), .addr(b_addr), .wdata(b_wdata), .rdata(b_rdata)
  );

  lbfs_ram #(.WIDTH($bits(file_entry_t)), .DEPTH(NUM_FILES)) u_table (
    .clk(clk), .we(t_we), .addr(t_addr), .wdata(ent), .rdata(t_rdata)
  );

  // State and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    cmd_r    <= cmd_next;
    file_r   <= file_next;
    din_r    <= din_next;
    ent      <= ent_next;
    walk_blk <= walk_blk_next;
    walk_n   <= walk_n_next;
    tries    <= tries_next;
    status_r <= status_next;
    dout_r   <= dout_next;
  end

  // Free map, table valid bits and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      free_map      <= '1;
      tbl_vld       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (free_clr) free_map[free_clr_idx] <= 1'b0;
      if (free_set) free_map[free_set_idx] <= 1'b1;
      if (state == S_DONE) tbl_vld[file_r] <= 1'b1;
      if (state == S_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_axis_tdata <= {5'd0, dout_r, status_r};
    end
  end

  // Command sequencer.
  always_comb begin
    state_next    = state;
    cmd_next      = cmd_r;
    file_next     = file_r;
    din_next      = din_r;
    ent_next      = ent;
    walk_blk_next = walk_blk;
    walk_n_next   = walk_n;
    tries_next    = tries;
    status_next   = status_r;
    dout_next     = dout_r;
    b_we          = 1'b0;
    b_addr        = '0;
    b_wdata       = '0;
    free_clr      = 1'b0;
    free_clr_idx  = alloc[BLK_W-1:0];
    free_set      = 1'b0;
    free_set_idx  = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd_next    = s_axis_tdata[2:0];
          file_next   = s_axis_tdata[8:3];
          din_next    = s_axis_tdata[16:9];
          status_next = ST_OK;
          dout_next   = 8'd0;
          tries_next  = 1'b0;
          walk_n_next = '0;
          state_next  = S_TBL;
        end
      end

      S_TBL: begin
        ent_next   = tbl_vld[file_r] ? t_rdata : ENTRY_RESET;
        state_next = S_EXEC;
      end

      S_EXEC: begin
        state_next = S_DONE;
        unique case (cmd_r)
          CMD_OPEN_WR, CMD_OPEN_APP: begin
            if (ent.mode != MODE_CLOSED) begin
              status_next = ST_OPEN;
            end else if (ent.start_blk == NO_BLOCK) begin
              // New file: one fresh empty block, nothing to walk.
              if (!alloc[BLK_W]) begin
                status_next = ST_SPACE;
              end else begin
                free_clr           = 1'b1;
                b_we               = 1'b1;
                b_addr             = {alloc[BLK_W-1:0], LINK_OFF};
                b_wdata            = NO_BLOCK;
                ent_next.start_blk = 8'(alloc[BLK_W-1:0]);
                ent_next.cur_blk   = 8'(alloc[BLK_W-1:0]);
                ent_next.pos       = 8'd0;
                ent_next.mode      = MODE_WRITE;
              end
            end else begin
              walk_blk_next = ent.start_blk[BLK_W-1:0];
              if (cmd_r == CMD_OPEN_APP) ent_next.cur_blk = ent.start_blk;
              state_next = S_WREQ;
            end
          end
          CMD_OPEN_RD: begin
            if (ent.mode != MODE_CLOSED) begin
              status_next = ST_OPEN;
            end else if (ent.start_blk == NO_BLOCK) begin
              status_next = ST_NOFILE;
            end else begin
              ent_next.pos     = 8'd0;
              ent_next.cur_blk = ent.start_blk;
              ent_next.mode    = MODE_READ;
            end
          end
          CMD_CLOSE: begin
            if (ent.start_blk == NO_BLOCK) begin
              status_next = ST_NOFILE;
            end else if (ent.mode != MODE_CLOSED) begin
              if (ent.cur_blk < 8'(NUM_BLOCKS)) begin
                b_we    = 1'b1;
                b_addr  = {ent.cur_blk[BLK_W-1:0], LINK_OFF};
                b_wdata = {1'b1, ent.pos[6:0]};
              end
              ent_next.cur_blk = NO_BLOCK;
              ent_next.mode    = MODE_CLOSED;
            end
          end
          CMD_WRITE: begin
            if (ent.mode != MODE_WRITE) begin
              status_next = ST_MODE;
            end else if (ent.cur_blk >= 8'(NUM_BLOCKS)) begin
              status_next = ST_SPACE;
            end else if (ent.pos >= DATA_BYTES) begin
              // Block full: chain a new one.
              if (!alloc[BLK_W]) begin
                status_next = ST_SPACE;
              end else begin
                free_clr         = 1'b1;
                b_we             = 1'b1;
                b_addr           = {ent.cur_blk[BLK_W-1:0], LINK_OFF};
                b_wdata          = 8'(alloc[BLK_W-1:0]);
                ent_next.cur_blk = 8'(alloc[BLK_W-1:0]);
                ent_next.pos     = 8'd0;
                state_next       = S_WNEW;
              end
            end else begin
              state_next = S_WBYTE;
            end
          end
          CMD_READ: begin
            if (ent.mode != MODE_READ) begin
              status_next = ST_MODE;
            end else begin
              state_next = S_RREQ;
            end
          end
          CMD_DELETE: begin
            if (ent.start_blk == NO_BLOCK) begin
              status_next = ST_NOFILE;
            end else if (ent.mode != MODE_CLOSED) begin
              status_next = ST_OPEN;
            end else begin
              walk_blk_next = ent.start_blk[BLK_W-1:0];
              state_next    = S_WREQ;
            end
          end
          CMD_EXISTS: begin
            if (ent.start_blk == NO_BLOCK) status_next = ST_NOFILE;
          end
          default: ;
        endcase
      end

      // Chain walk for truncate, append and delete.
      S_WREQ: begin
        b_addr     = {walk_blk, LINK_OFF};
        state_next = S_WDAT;
      end

      S_WDAT: begin
        if (!lnk[7] && walk_n < (BLK_W+1)'(NUM_BLOCKS)) begin
          walk_n_next   = walk_n + 1'b1;
          walk_blk_next = lnk[BLK_W-1:0];
          if (cmd_r == CMD_OPEN_APP) begin
            ent_next.cur_blk = lnk;
          end else begin
            free_set     = 1'b1;
            free_set_idx = lnk[BLK_W-1:0];
          end
          state_next = S_WREQ;
        end else begin
          state_next = S_DONE;
          if (cmd_r == CMD_OPEN_APP) begin
            ent_next.pos  = lnk[7] ? end_len(lnk, 8'd0) : 8'd0;
            ent_next.mode = MODE_WRITE;
          end else begin
            b_we    = 1'b1;
            b_addr  = {ent.start_blk[BLK_W-1:0], LINK_OFF};
            b_wdata = NO_BLOCK;
            if (cmd_r == CMD_OPEN_WR) begin
              ent_next.pos     = 8'd0;
              ent_next.cur_blk = ent.start_blk;
              ent_next.mode    = MODE_WRITE;
            end else begin
              free_set           = 1'b1;
              free_set_idx       = ent.start_blk[BLK_W-1:0];
              ent_next.start_blk = NO_BLOCK;
            end
          end
        end
      end

      // Mark a freshly chained block as an empty last block.
      S_WNEW: begin
        b_we       = 1'b1;
        b_addr     = {ent.cur_blk[BLK_W-1:0], LINK_OFF};
        b_wdata    = NO_BLOCK;
        state_next = S_WBYTE;
      end

      S_WBYTE: begin
        b_we         = 1'b1;
        b_addr       = {ent.cur_blk[BLK_W-1:0], ent.pos[OFF_W-1:0]};
        b_wdata      = din_r;
        ent_next.pos = ent.pos + 8'd1;
        state_next   = S_DONE;
      end

      // Read: fetch the link, then the byte or step to the next block once.
      S_RREQ: begin
        if (ent.cur_blk >= 8'(NUM_BLOCKS)) begin
          status_next = ST_EOF;
          state_next  = S_DONE;
        end else begin
          b_addr     = {ent.cur_blk[BLK_W-1:0], LINK_OFF};
          state_next = S_RLNK;
        end
      end

      S_RLNK: begin
        if (ent.pos < rlen) begin
          b_addr     = {ent.cur_blk[BLK_W-1:0], ent.pos[OFF_W-1:0]};
          state_next = S_RBYTE;
        end else if (lnk[7]) begin
          status_next = ST_EOF;
          state_next  = S_DONE;
        end else begin
          ent_next.cur_blk = lnk;
          ent_next.pos     = 8'd0;
          if (tries) begin
            status_next = ST_EOF;
            state_next  = S_DONE;
          end else begin
            tries_next = 1'b1;
            state_next = S_RREQ;
          end
        end
      end

      S_RBYTE: begin
        dout_next    = b_rdata;
        ent_next.pos = ent.pos + 8'd1;
        state_next   = S_DONE;
      end

      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Checks on the sequencer.
  a_accept_tbl: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_TBL) else $error("table read did not follow accept");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_WREQ |-> walk_n <= (BLK_W+1)'(NUM_BLOCKS))
    else $error("chain walk overran its bound");

  a_take_free: assert property (@(posedge clk) disable iff (rst)
    free_clr |-> free_map[free_clr_idx]) else $error("allocated a used block");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= ST_EOF) else $error("bad status code");

  a_dout_ok: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[10:3] != 8'd0) |-> m_axis_tdata[2:0] == ST_OK)
    else $error("data returned with failing status");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench
  import lbfs_pkg::*;
;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // cmd, file, data_in, zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // status, data_out, zero pad

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] data_out;
  } fs_result_t;

  // Shadow copy of the file store state.
  logic [7:0] shadow_mem [STORE_DEPTH];
  logic       shadow_free [NUM_BLOCKS];
  logic [7:0] shadow_start [NUM_FILES];
  logic [1:0] shadow_mode [NUM_FILES];
  logic [7:0] shadow_pos [NUM_FILES];
  logic [7:0] shadow_cur [NUM_FILES];

  fs_result_t pending_results[$];
  int         error_count;
  int         sent_count;
  int         checked_count;
  int         send_idle_pct;
  int         recv_stall_pct;

  linked_block_file_store_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock generation.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [7:0] link_of(input logic [7:0] b);
    logic [7:0] v;
    if (b >= NUM_BLOCKS) return NO_BLOCK;
    v = shadow_mem[b * BLOCK_BYTES + BLOCK_BYTES - 1];
    if (!v[7] && v >= NUM_BLOCKS) return NO_BLOCK;
    return v;
  endfunction

  function automatic void put_link(input logic [7:0] b, input logic [7:0] v);
    if (b < NUM_BLOCKS) shadow_mem[b * BLOCK_BYTES + BLOCK_BYTES - 1] = v;
  endfunction

  function automatic logic [7:0] grab_block();
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      if (shadow_free[i]) begin
        shadow_free[i] = 1'b0;
        return 8'(i);
      end
    end
    return NO_BLOCK;
  endfunction

  function automatic logic [7:0] tail_length(input logic [7:0] l, input logic [7:0] when_empty);
    if (l == NO_BLOCK) return when_empty;
    if (l[6:0] > DATA_BYTES) return DATA_BYTES;
    return {1'b0, l[6:0]};
  endfunction

  // Frees every block after the first one and marks the first as an empty end.
  function automatic void truncate_chain(input int f);
    logic [7:0] l;
    int n;
    n = 0;
    if (shadow_start[f] == NO_BLOCK) return;
    l = link_of(shadow_start[f]);
    while (!l[7] && n < NUM_BLOCKS) begin
      if (l < NUM_BLOCKS) shadow_free[l] = 1'b1;
      l = link_of(l);
      n++;
    end
    put_link(shadow_start[f], NO_BLOCK);
  endfunction

  function automatic bit make_file(input int f);
    logic [7:0] b;
    if (shadow_start[f] != NO_BLOCK) return 1'b1;
    b = grab_block();
    if (b == NO_BLOCK) return 1'b0;
    shadow_start[f] = b;
    put_link(b, NO_BLOCK);
    return 1'b1;
  endfunction

  function automatic fs_result_t predict_command(input logic [2:0] cmd, input int f,
                                                 input logic [7:0] din);
    fs_result_t r;
    logic [7:0] cur, pos, l, len, nb;
    int n;
    r = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_OPEN_WR: begin
        if (shadow_mode[f] != MODE_CLOSED) r.status = ST_OPEN;
        else if (!make_file(f)) r.status = ST_SPACE;
        else begin
          truncate_chain(f);
          shadow_pos[f] = 8'd0;
          shadow_cur[f] = shadow_start[f];
          shadow_mode[f] = MODE_WRITE;
        end
      end
      CMD_OPEN_APP: begin
        if (shadow_mode[f] != MODE_CLOSED) r.status = ST_OPEN;
        else if (!make_file(f)) r.status = ST_SPACE;
        else begin
          // Walk to the last block and resume after its stored length.
          shadow_cur[f] = shadow_start[f];
          l = link_of(shadow_start[f]);
          n = 0;
          while (!l[7] && n < NUM_BLOCKS) begin
            shadow_cur[f] = l;
            l = link_of(l);
            n++;
          end
          shadow_pos[f] = l[7] ? tail_length(l, 8'd0) : 8'd0;
          shadow_mode[f] = MODE_WRITE;
        end
      end
      CMD_OPEN_RD: begin
        if (shadow_mode[f] != MODE_CLOSED) r.status = ST_OPEN;
        else if (shadow_start[f] == NO_BLOCK) r.status = ST_NOFILE;
        else begin
          shadow_pos[f] = 8'd0;
          shadow_cur[f] = shadow_start[f];
          shadow_mode[f] = MODE_READ;
        end
      end
      CMD_CLOSE: begin
        if (shadow_start[f] == NO_BLOCK) r.status = ST_NOFILE;
        else if (shadow_mode[f] != MODE_CLOSED) begin
          if (shadow_cur[f] < NUM_BLOCKS)
            put_link(shadow_cur[f], {1'b1, shadow_pos[f][6:0]});
          shadow_cur[f] = NO_BLOCK;
          shadow_mode[f] = MODE_CLOSED;
        end
      end
      CMD_WRITE: begin
        if (shadow_mode[f] != MODE_WRITE) r.status = ST_MODE;
        else begin
          cur = shadow_cur[f];
          pos = shadow_pos[f];
          if (cur >= NUM_BLOCKS) r.status = ST_SPACE;
          else begin
            nb = 8'd0;
            if (pos >= DATA_BYTES) begin
              nb = grab_block();
              if (nb != NO_BLOCK) begin
                put_link(cur, nb);
                put_link(nb, NO_BLOCK);
                cur = nb;
                pos = 8'd0;
                shadow_cur[f] = cur;
              end
            end
            if (nb == NO_BLOCK) r.status = ST_SPACE;
            else begin
              shadow_mem[cur * BLOCK_BYTES + pos] = din;
              shadow_pos[f] = 8'(pos + 8'd1);
            end
          end
        end
      end
      CMD_READ: begin
        if (shadow_mode[f] != MODE_READ) r.status = ST_MODE;
        else begin
          cur = shadow_cur[f];
          pos = shadow_pos[f];
          r.status = ST_EOF;
          // At most one hop to the next block of the chain.
          for (int t = 0; t < 2; t++) begin
            if (cur >= NUM_BLOCKS) break;
            l = link_of(cur);
            len = l[7] ? tail_length(l, DATA_BYTES) : DATA_BYTES;
            if (pos < len) begin
              r.data_out = shadow_mem[cur * BLOCK_BYTES + pos];
              shadow_pos[f] = 8'(pos + 8'd1);
              r.status = ST_OK;
              break;
            end
            if (l[7]) break;
            cur = l;
            pos = 8'd0;
            shadow_cur[f] = cur;
            shadow_pos[f] = 8'd0;
          end
        end
      end
      CMD_DELETE: begin
        if (shadow_start[f] == NO_BLOCK) r.status = ST_NOFILE;
        else if (shadow_mode[f] != MODE_CLOSED) r.status = ST_OPEN;
        else begin
          truncate_chain(f);
          if (shadow_start[f] < NUM_BLOCKS) shadow_free[shadow_start[f]] = 1'b1;
          shadow_start[f] = NO_BLOCK;
        end
      end
      default: r.status = (shadow_start[f] != NO_BLOCK) ? ST_OK : ST_NOFILE;
    endcase
    return r;
  endfunction

  // Drives one command and records its predicted result.
  task automatic send_command(input logic [2:0] cmd, input logic [5:0] f,
                              input logic [7:0] din);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, din, f, cmd};
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(predict_command(cmd, int'(f), din));
    sent_count++;
  endtask

  // The receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // Compares each result transaction with the oldest prediction.
  always @(posedge clk) begin
    fs_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      checked_count++;
      if (pending_results.size() == 0) begin
        $error("Result transaction with no command outstanding: %h", m_axis_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[2:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tdata[2:0]);
          error_count++;
        end
        if (m_axis_tdata[10:3] !== want.data_out) begin
          $error("data_out: expected %0d, got %0d", want.data_out, m_axis_tdata[10:3]);
          error_count++;
        end
      end
    end
  end

  // Stops sending and waits until every expected result has come.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Picks file 0 to 5 mostly, any file from 0 to 63 otherwise.
  function automatic logic [5:0] pick_file();
    return ($urandom_range(9) < 8) ? 6'($urandom_range(5)) : 6'($urandom_range(63));
  endfunction

  // Every command, the extremes of the fields and the special cases.
  task automatic test_directed();
    send_command(CMD_EXISTS, 6'd63, 8'hFF);
    send_command(CMD_OPEN_RD, 6'd0, 8'd0);
    send_command(CMD_CLOSE, 6'd0, 8'd0);
    send_command(CMD_DELETE, 6'd0, 8'd0);
    send_command(CMD_OPEN_WR, 6'd0, 8'd0);
    send_command(CMD_OPEN_WR, 6'd0, 8'd0);
    send_command(CMD_READ, 6'd0, 8'd0);
    send_command(CMD_WRITE, 6'd0, 8'h00);
    send_command(CMD_WRITE, 6'd0, 8'hFF);
    send_command(CMD_WRITE, 6'd0, 8'hA5);
    send_command(CMD_DELETE, 6'd0, 8'd0);
    send_command(CMD_CLOSE, 6'd0, 8'd0);
    send_command(CMD_EXISTS, 6'd0, 8'd0);
    send_command(CMD_OPEN_RD, 6'd0, 8'd0);
    send_command(CMD_WRITE, 6'd0, 8'h5A);
    for (int i = 0; i < 4; i++) send_command(CMD_READ, 6'd0, 8'd0);
    send_command(CMD_CLOSE, 6'd0, 8'd0);
    send_command(CMD_OPEN_APP, 6'd63, 8'd0);
    send_command(CMD_WRITE, 6'd63, 8'h3C);
    send_command(CMD_CLOSE, 6'd63, 8'd0);
    send_command(CMD_DELETE, 6'd63, 8'd0);
    send_command(CMD_EXISTS, 6'd63, 8'd0);
  endtask

  // Writes fill several blocks, then appending resumes in the last block and reading back crosses block edges.
  task automatic test_long_file();
    send_command(CMD_OPEN_WR, 6'd1, 8'd0);
    for (int i = 0; i < 70; i++) send_command(CMD_WRITE, 6'd1, 8'($urandom_range(255)));
    send_command(CMD_CLOSE, 6'd1, 8'd0);
    send_command(CMD_OPEN_APP, 6'd1, 8'd0);
    for (int i = 0; i < 5; i++) send_command(CMD_WRITE, 6'd1, 8'($urandom_range(255)));
    send_command(CMD_CLOSE, 6'd1, 8'd0);
    send_command(CMD_OPEN_RD, 6'd1, 8'd0);
    for (int i = 0; i < 77; i++) send_command(CMD_READ, 6'd1, 8'd0);
    send_command(CMD_CLOSE, 6'd1, 8'd0);
  endtask

  // Runs the store out of blocks, then frees them again.
  task automatic test_out_of_space();
    // Empty files take most blocks first so the long file fills up quickly.
    for (int i = 8; i < 56; i++) send_command(CMD_OPEN_WR, 6'(i), 8'd0);
    send_command(CMD_OPEN_WR, 6'd2, 8'd0);
    for (int i = 0; i < 64 * 31; i++) begin
      send_command(CMD_WRITE, 6'd2, 8'($urandom_range(255)));
      if (pending_results[$].status == ST_SPACE) break;
    end
    send_command(CMD_WRITE, 6'd2, 8'h11);
    send_command(CMD_OPEN_WR, 6'd60, 8'd0);
    send_command(CMD_CLOSE, 6'd2, 8'd0);
    send_command(CMD_DELETE, 6'd2, 8'd0);
    send_command(CMD_DELETE, 6'd1, 8'd0);
    for (int i = 8; i < 56; i++) begin
      send_command(CMD_CLOSE, 6'(i), 8'd0);
      send_command(CMD_DELETE, 6'(i), 8'd0);
    end
  endtask

  // Mostly well-formed open, write or read, close sessions with random noise.
  task automatic test_random(input int count);
    logic [5:0] f;
    int n;
    while (count > 0) begin
      f = pick_file();
      if ($urandom_range(9) < 7) begin
        case ($urandom_range(2))
          0: send_command(CMD_OPEN_WR, f, 8'd0);
          1: send_command(CMD_OPEN_APP, f, 8'd0);
          default: send_command(CMD_OPEN_RD, f, 8'd0);
        endcase
        n = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(8);
        for (int i = 0; i < n; i++)
          send_command(shadow_mode[f] == MODE_READ ? CMD_READ : CMD_WRITE, f,
                       8'($urandom_range(255)));
        if ($urandom_range(9) != 0) send_command(CMD_CLOSE, f, 8'd0);
        if ($urandom_range(7) == 0) send_command(CMD_DELETE, f, 8'd0);
        count -= n + 2;
      end else begin
        // Random noise: any command on the file, with random data.
        send_command(3'($urandom_range(7)), f, 8'($urandom_range(255)));
        count--;
      end
    end
  endtask

  initial begin
    error_count = 0;
    sent_count = 0;
    checked_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    for (int i = 0; i < STORE_DEPTH; i++) shadow_mem[i] = 8'd0;
    for (int i = 0; i < NUM_BLOCKS; i++) shadow_free[i] = 1'b1;
    for (int i = 0; i < NUM_FILES; i++) begin
      shadow_start[i] = NO_BLOCK;
      shadow_mode[i] = MODE_CLOSED;
      shadow_pos[i] = 8'd0;
      shadow_cur[i] = NO_BLOCK;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_long_file();
    wait_drained();
    test_out_of_space();
    test_random(275);
    send_idle_pct = 52;
    test_random(275);
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 52;
    test_random(275);
    send_idle_pct = 21;
    recv_stall_pct = 21;
    test_random(275);

    wait_drained();
    repeat (200) @(posedge clk);
    $display("Sent %0d commands over four idling phases; %0d results checked.",
             sent_count, checked_count);
    $display("Covered every command, chained blocks, append, end of file and full store.");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
